@@ hdl/set_assoc_cache_lfu_lookup_assert.svh @@
// assertion macros for the cache lookup rtl
`ifndef SET_ASSOC_CACHE_LFU_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_LFU_LOOKUP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SACL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sacl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// shared constants and types of the set-associative lfu cache lookup
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ENTRIES_DEFAULT      = 256;
  localparam int ADDRESS_BITS_DEFAULT = 32;
  localparam int COUNT_BITS_DEFAULT   = 16;

  localparam int WAYS_LOG2_BITS = 4;
  localparam int WAY_BITS       = 8;
  localparam int TOTAL_BITS     = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int PADDR_BITS     = 3;

  localparam logic [0:0] REG_WAYS_LOG2 = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } sacl_state_t;

endpackage

@@ hdl/sacl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/set_assoc_cache_lfu_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lfu_lookup
// set-associative cache lookup with least-frequently-used replacement
// ----------------------------------------------------------------------------
// one request on the input channel carries an address; one result leaves on
// the output channel: hit flag, way, and running hit and miss totals.
// ways = 1 << ways_log2 (clamped to log2 of ENTRIES), written over the apb
// port at byte address 0; it is to be written only while the block is idle,
// which the block itself does not enforce. ENTRIES is to be a power of two,
// which the block does not check. tags and use counts live in one ram with a
// registered read; the set is read one way per cycle, tag match and minimum
// count found in the same pass, then the write-back state updates the entry.
// ways range from 1 to ENTRIES; one request at a time, the next is not taken
// until the result of the last has been loaded into the output register.
// a new request is accepted while the previous result waits in the output
// register; a stalled receiver holds the block in write-back until the
// output register frees.
// reset empties every entry (valid flops cleared at once, no sweep), clears
// the totals and sets ways_log2 to 0 (direct mapped).
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lfu_lookup_assert.svh"

module set_assoc_cache_lfu_lookup #(
  parameter int ENTRIES      = sacl_pkg::ENTRIES_DEFAULT,
  parameter int ADDRESS_BITS = sacl_pkg::ADDRESS_BITS_DEFAULT,
  parameter int COUNT_BITS   = sacl_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sacl_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [sacl_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [sacl_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ADDRESS_BITS-1:0]            address,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               hit,
  output logic [sacl_pkg::WAY_BITS-1:0]      way,
  output logic [sacl_pkg::TOTAL_BITS-1:0]    hit_total,
  output logic [sacl_pkg::TOTAL_BITS-1:0]    miss_total
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int LG_W   = $clog2(IDX_W + 1);
  localparam int DATA_W = ADDRESS_BITS + COUNT_BITS;

  sacl_pkg::sacl_state_t state, state_next;

  logic [sacl_pkg::WAYS_LOG2_BITS-1:0] ways_log2;
  logic                                cfg_wr;

  logic [LG_W-1:0]         lg_eff;
  logic [IDX_W-1:0]        addr_low;
  logic [IDX_W-1:0]        set_mask;

  logic [ADDRESS_BITS-1:0] addr_q;
  logic [IDX_W-1:0]        base_q;
  logic [IDX_W:0]          ways_q;
  logic [IDX_W:0]          rd_w;
  logic [IDX_W:0]          cmp_w;
  logic                    cmp_vld;
  logic                    vbit_q;
  logic                    issue;
  logic [IDX_W-1:0]        rd_idx;

  logic                    hit_q;
  logic [IDX_W-1:0]        found_w;
  logic [COUNT_BITS-1:0]   found_cnt;
  logic [COUNT_BITS-1:0]   best_cnt;
  logic [IDX_W-1:0]        victim_w;

  logic [ENTRIES-1:0]      entry_valid;
  logic                    ram_we;
  logic                    load_out;
  logic [IDX_W-1:0]        wr_w;
  logic [IDX_W-1:0]        wr_idx;
  logic [DATA_W-1:0]       wr_data;
  logic [DATA_W-1:0]       rd_data;
  logic [COUNT_BITS-1:0]   rd_cnt;
  logic [COUNT_BITS-1:0]   eff_cnt;
  logic [ADDRESS_BITS-1:0] rd_tag;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic                    accept;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == sacl_pkg::REG_WAYS_LOG2) begin
      prdata = sacl_pkg::CFG_DATA_BITS'(ways_log2);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_log2 <= '0;
    end else if (cfg_wr && paddr[2] == sacl_pkg::REG_WAYS_LOG2) begin
      ways_log2 <= pwdata[sacl_pkg::WAYS_LOG2_BITS-1:0];
    end
  end

  // set geometry for the incoming request
  assign lg_eff   = (ways_log2 > sacl_pkg::WAYS_LOG2_BITS'(IDX_W)) ?
                    LG_W'(IDX_W) : LG_W'(ways_log2);
  assign addr_low = IDX_W'(address);
  assign set_mask = {IDX_W{1'b1}} >> lg_eff;

  assign in_ready = (state == sacl_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sacl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      sacl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sacl_pkg::ST_SCAN;
        end
      end
      sacl_pkg::ST_SCAN: begin
        issue = (rd_w < ways_q);
        if (cmp_vld && cmp_w == ways_q - (IDX_W + 1)'(1)) begin
          state_next = sacl_pkg::ST_WRITE;
        end
      end
      sacl_pkg::ST_WRITE: begin
        if (!out_valid || out_ready) begin
          ram_we     = 1'b1;
          load_out   = 1'b1;
          state_next = sacl_pkg::ST_IDLE;
        end
      end
      default: state_next = sacl_pkg::ST_IDLE;
    endcase
  end

  // scan datapath
  assign rd_idx  = base_q | rd_w[IDX_W-1:0];
  assign rd_tag  = rd_data[ADDRESS_BITS-1:0];
  assign rd_cnt  = rd_data[ADDRESS_BITS +: COUNT_BITS];
  assign eff_cnt = vbit_q ? rd_cnt : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q <= address;
      base_q <= (addr_low & set_mask) << lg_eff;
      ways_q <= (IDX_W + 1)'(1) << lg_eff;
      rd_w   <= '0;
      hit_q  <= 1'b0;
    end else if (issue) begin
      rd_w <= rd_w + (IDX_W + 1)'(1);
    end
    cmp_w  <= rd_w;
    vbit_q <= entry_valid[rd_idx];
    if (cmp_vld) begin
      if (!hit_q && vbit_q && rd_tag == addr_q) begin
        hit_q     <= 1'b1;
        found_w   <= cmp_w[IDX_W-1:0];
        found_cnt <= rd_cnt;
      end
      if (cmp_w == '0 || eff_cnt < best_cnt) begin
        best_cnt <= eff_cnt;
        victim_w <= cmp_w[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= issue;
    end
  end

  // write-back
  assign wr_w    = hit_q ? found_w : victim_w;
  assign wr_idx  = base_q | wr_w;
  assign cnt_inc = (found_cnt == {COUNT_BITS{1'b1}}) ? found_cnt :
                   found_cnt + COUNT_BITS'(1);
  assign wr_data = hit_q ? {cnt_inc, addr_q} : {{COUNT_BITS{1'b0}}, addr_q};

  sacl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (wr_data),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      hit_total   <= '0;
      miss_total  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (ram_we) begin
        entry_valid[wr_idx] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        if (hit_q) begin
          hit_total <= hit_total + sacl_pkg::TOTAL_BITS'(1);
        end else begin
          miss_total <= miss_total + sacl_pkg::TOTAL_BITS'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hit <= hit_q;
      way <= sacl_pkg::WAY_BITS'(wr_w);
    end
  end

  // checks
  `SACL_ASSERT_SAME(a_scan_bound, clk, rst, state == sacl_pkg::ST_SCAN, rd_w <= ways_q,
    "scan ran past the last way")
  `SACL_ASSERT_NEXT(a_accept_scan, clk, rst, accept,
    state == sacl_pkg::ST_SCAN && !hit_q && rd_w == '0, "request did not start a scan")
  `SACL_ASSERT_NEXT(a_one_total, clk, rst, load_out,
    sacl_pkg::TOTAL_BITS'(hit_total + miss_total) ==
    sacl_pkg::TOTAL_BITS'($past(hit_total + miss_total) + 1), "totals moved by other than one")
  `SACL_ASSERT_SAME(a_cmp_in_scan, clk, rst, cmp_vld, state == sacl_pkg::ST_SCAN,
    "compare stage active outside the scan")

endmodule
